>>> rtl/core/rta_pkg.sv
// Shared types, constants and register codes for the rational tick accumulator.
package rta_pkg;

   // Datapath widths
   localparam int DATA_W      = 64;
   localparam int MUL_B_W     = 20;
   localparam int TICKS_W     = 43;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 48;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 18;

   // Valid ranges of the settings and the delta
   localparam logic [17:0]        RATE_NUM_MIN  = 18'd1;
   localparam logic [17:0]        RATE_NUM_MAX  = 18'd240000;
   localparam logic [16:0]        RATE_DEN_MIN  = 17'd1;
   localparam logic [16:0]        RATE_DEN_MAX  = 17'd100000;
   localparam logic signed [14:0] SPEED_NUM_MIN = -15'sd10000;
   localparam logic signed [14:0] SPEED_NUM_MAX = 15'sd10000;
   localparam logic [13:0]        SPEED_DEN_MIN = 14'd1;
   localparam logic [13:0]        SPEED_DEN_MAX = 14'd10000;
   localparam logic [29:0]        MAX_ADVANCE   = 30'd1000000000;

   // Nanoseconds per tick scale, used as a multiplier operand
   localparam logic [MUL_B_W-1:0] NS_SCALE = 20'd1000000;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_RATE  = 2'd1,
      ST_BAD_SPEED = 2'd2,
      ST_BAD_DELTA = 2'd3
   } status_type;

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_RATE_NUM  = 2'd0,
      REG_RATE_DEN  = 2'd1,
      REG_SPEED_NUM = 2'd2,
      REG_SPEED_DEN = 2'd3
   } reg_index_type;

   // Multiplier command and answer
   typedef struct packed {
      logic               start;
      logic [DATA_W-1:0]  a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] prod;
   } mul_rsp_type;

   // Divider command and answer
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quo;
      logic [DATA_W-1:0] rem;
   } div_rsp_type;

endpackage

>>> rtl/core/rta_ser_mul.sv
// Shift-add multiplier that retires one multiplier bit per cycle.
module rta_ser_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  rta_pkg::mul_req_type mul_req,
   output rta_pkg::mul_rsp_type mul_rsp
);
   import rta_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

   logic [DATA_W-1:0]  a_ff, a_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   // Load operands, then add the shifted multiplicand for each set bit
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         a_in    = mul_req.a;
         b_in    = mul_req.b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + (b_ff[0] ? a_ff : '0);
         a_in   = {a_ff[DATA_W-2:0], 1'b0};
         b_in   = {1'b0, b_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = acc_ff;

endmodule

>>> rtl/core/rta_ser_div.sv
// Restoring divider that produces one quotient bit per cycle.
module rta_ser_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rta_pkg::div_req_type div_req,
   output rta_pkg::div_rsp_type div_rsp
);
   import rta_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W-1:0] trial;
   logic              fits;

   // Shift the next dividend bit into the partial remainder
   assign trial = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
   assign fits  = (trial >= dvs_ff);

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - dvs_ff) : trial;
         quo_in = {quo_ff[DATA_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

>>> rtl/core/rational_tick_accumulator_core.sv
// An accepted word passes through four shift-add multiplies (delta*rate, *speed,
// rate_den*speed_den, *1e6), a step to add the residual and one to take the magnitude, the
// 64-step restoring divide and a final step that loads the output register once it is free.
// A word rejected by the range checks goes straight to that final step to show its error result.
// The core takes one word at a time and accepts the next only after the result is loaded;
// reset (synchronous) clears the residual, loads rate 30/1, speed 1/1, leaves no result.
module rational_tick_accumulator_core (
   input  logic                              clock,
   input  logic                              reset,
   // Input words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rta_pkg::REQ_DATA_W-1:0]    req_tdata,   // [30:0] delta_ns
   // Result words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rta_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [42:0] ticks
   output logic [1:0]                        rsp_tuser,   // [1:0] status
   // Configuration writes
   input  logic                              csr_we,
   input  logic [rta_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rta_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rta_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_DR, S_MUL_SP, S_MUL_RS, S_MUL_SC,
      S_SUM, S_ABS, S_DIV, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [17:0]        rate_num_ff, rate_num_in;
   logic [16:0]        rate_den_ff, rate_den_in;
   logic signed [14:0] speed_num_ff, speed_num_in;
   logic [13:0]        speed_den_ff, speed_den_in;
   logic [DATA_W-1:0]  residual_ff, residual_in;
   logic [DATA_W-1:0]  num_ff, num_in;
   logic [DATA_W-1:0]  den_ff, den_in;
   logic [DATA_W-1:0]  sum_ff, sum_in;
   logic [TICKS_W-1:0] quo_ff, quo_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TICKS_W-1:0] rsp_ticks_ff, rsp_ticks_in;
   status_type         rsp_status_ff, rsp_status_in;
   mul_req_type        mul_req_ff, mul_req_in;
   div_req_type        div_req_ff, div_req_in;
   mul_rsp_type        mul_rsp;
   div_rsp_type        div_rsp;

   logic               rate_ok, speed_ok, delta_ok;
   logic [14:0]        speed_mag;
   logic [DATA_W-1:0]  neg_quo;

   rta_ser_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req_ff),
      .mul_rsp (mul_rsp)
   );

   rta_ser_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   // Range checks on the settings and the incoming delta
   assign rate_ok  = (rate_num_ff inside {[RATE_NUM_MIN:RATE_NUM_MAX]}) &&
                     (rate_den_ff inside {[RATE_DEN_MIN:RATE_DEN_MAX]});
   assign speed_ok = (speed_num_ff >= SPEED_NUM_MIN) && (speed_num_ff <= SPEED_NUM_MAX) &&
                     (speed_den_ff inside {[SPEED_DEN_MIN:SPEED_DEN_MAX]});
   assign delta_ok = !req_tdata[30] && (req_tdata[29:0] <= MAX_ADVANCE);

   assign speed_mag = speed_num_ff[14] ? (~speed_num_ff + 15'd1) : speed_num_ff;
   assign neg_quo   = ~div_rsp.quo + 64'd1;

   always_comb begin
      state_in      = state_ff;
      rate_num_in   = rate_num_ff;
      rate_den_in   = rate_den_ff;
      speed_num_in  = speed_num_ff;
      speed_den_in  = speed_den_ff;
      residual_in   = residual_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      sum_in        = sum_ff;
      quo_in        = quo_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_ticks_in  = rsp_ticks_ff;
      rsp_status_in = rsp_status_ff;
      mul_req_in    = mul_req_ff;
      div_req_in    = div_req_ff;
      mul_req_in.start = 1'b0;
      div_req_in.start = 1'b0;

      // Drop the output word once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Take configuration writes
      if (csr_we) begin
         case (csr_addr)
            REG_RATE_NUM:  rate_num_in  = csr_wdata[17:0];
            REG_RATE_DEN:  rate_den_in  = csr_wdata[16:0];
            REG_SPEED_NUM: speed_num_in = csr_wdata[14:0];
            REG_SPEED_DEN: speed_den_in = csr_wdata[13:0];
            default: ;
         endcase
      end

      // Sequence one word through range checks, multiply, accumulate and divide
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               quo_in   = '0;
               state_in = S_DONE;
               if (!rate_ok) begin
                  status_in = ST_BAD_RATE;
               end else if (!speed_ok) begin
                  status_in = ST_BAD_SPEED;
               end else if (!delta_ok) begin
                  status_in = ST_BAD_DELTA;
               end else begin
                  status_in  = ST_OK;
                  mul_req_in = '{start: 1'b1, a: {33'd0, req_tdata[30:0]},
                                 b: {2'd0, rate_num_ff}};
                  state_in   = S_MUL_DR;
               end
            end
         end
         S_MUL_DR: begin
            if (mul_rsp.done) begin
               mul_req_in = '{start: 1'b1, a: mul_rsp.prod, b: {5'd0, speed_mag}};
               state_in   = S_MUL_SP;
            end
         end
         S_MUL_SP: begin
            if (mul_rsp.done) begin
               num_in     = speed_num_ff[14] ? (~mul_rsp.prod + 64'd1) : mul_rsp.prod;
               mul_req_in = '{start: 1'b1, a: {47'd0, rate_den_ff}, b: {6'd0, speed_den_ff}};
               state_in   = S_MUL_RS;
            end
         end
         S_MUL_RS: begin
            if (mul_rsp.done) begin
               mul_req_in = '{start: 1'b1, a: mul_rsp.prod, b: NS_SCALE};
               state_in   = S_MUL_SC;
            end
         end
         S_MUL_SC: begin
            if (mul_rsp.done) begin
               den_in   = mul_rsp.prod;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            sum_in   = residual_ff + num_ff;
            state_in = S_ABS;
         end
         S_ABS: begin
            // Divide the magnitude; floor is restored afterward
            div_req_in = '{start: 1'b1,
                           dividend: sum_ff[DATA_W-1] ? (~sum_ff + 64'd1) : sum_ff,
                           divisor: den_ff};
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (!sum_ff[DATA_W-1]) begin
                  quo_in      = div_rsp.quo[TICKS_W-1:0];
                  residual_in = div_rsp.rem;
               end else if (div_rsp.rem == '0) begin
                  quo_in      = neg_quo[TICKS_W-1:0];
                  residual_in = '0;
               end else begin
                  quo_in      = ~div_rsp.quo[TICKS_W-1:0];
                  residual_in = den_ff - div_rsp.rem;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_ticks_in  = quo_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff        <= num_in;
      den_ff        <= den_in;
      sum_ff        <= sum_in;
      quo_ff        <= quo_in;
      status_ff     <= status_in;
      rsp_ticks_ff  <= rsp_ticks_in;
      rsp_status_ff <= rsp_status_in;
      mul_req_ff.a  <= mul_req_in.a;
      mul_req_ff.b  <= mul_req_in.b;
      div_req_ff.dividend <= div_req_in.dividend;
      div_req_ff.divisor  <= div_req_in.divisor;
      if (reset) begin
         state_ff         <= S_IDLE;
         rate_num_ff      <= 18'd30;
         rate_den_ff      <= 17'd1;
         speed_num_ff     <= 15'sd1;
         speed_den_ff     <= 14'd1;
         residual_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
         mul_req_ff.start <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         state_ff         <= state_in;
         rate_num_ff      <= rate_num_in;
         rate_den_ff      <= rate_den_in;
         speed_num_ff     <= speed_num_in;
         speed_den_ff     <= speed_den_in;
         residual_ff      <= residual_in;
         rsp_valid_ff     <= rsp_valid_in;
         mul_req_ff.start <= mul_req_in.start;
         div_req_ff.start <= div_req_in.start;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-TICKS_W){1'b0}}, rsp_ticks_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

>>> rtl/core/rta_checker.sv
// Port-level assertions for the rational tick accumulator, bound to the top level.
module rta_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rta_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                     rsp_tuser
);
   import rta_pkg::*;

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word pending after reset");

   // An error result carries zero ticks
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata == '0))
      else $error("error result with nonzero ticks");

   // One word in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word accepted while one is in flight");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

endmodule

bind rational_tick_accumulator_core rta_checker u_rta_checker (.*);
